@@ rtl/wsg_pkg.sv @@
// Shared constants, register and mode codes, and the sine table generator for the DDS source.
package wsg_pkg;

	localparam int PHASE_BITS_DEF      = 32;
	localparam int SINE_TABLE_BITS_DEF = 10;
	localparam int CFG_INDEX_W         = 2;
	localparam int SAMPLE_W            = 16;

	// register map
	localparam logic [CFG_INDEX_W-1:0] REG_WAVE_MODE  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_AMPLITUDE  = 2'd2;

	// waveform codes
	localparam logic [2:0] MODE_SINE     = 3'd0;
	localparam logic [2:0] MODE_COSINE   = 3'd1;
	localparam logic [2:0] MODE_TRIANGLE = 3'd2;
	localparam logic [2:0] MODE_SQUARE   = 3'd3;
	localparam logic [2:0] MODE_CONSTANT = 3'd4;

	// Q0.32 phase points
	localparam logic [31:0] PH_QUARTER       = 32'h4000_0000;
	localparam logic [31:0] PH_HALF          = 32'h8000_0000;
	localparam logic [31:0] PH_THREE_QUARTER = 32'hC000_0000;

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] ONE_Q30     = 64'd1073741824;

	// Quarter-wave sine entry k in Q1.15, integer Taylor series to the x^17 term.
	// Only ever called with elaboration-time constants.
	function automatic logic [15:0] sine_entry(input int unsigned k, input int unsigned tab_bits);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] entry;
		x    = (64'(k) * HALF_PI_Q30) >> tab_bits;
		x2   = (x * x) >> 30;
		term = x;
		sum  = x;
		term = ((term * x2) >> 30) / 64'd6;
		sum  = (term > sum) ? 64'd0 : sum - term;
		term = ((term * x2) >> 30) / 64'd20;
		sum  = sum + term;
		term = ((term * x2) >> 30) / 64'd42;
		sum  = (term > sum) ? 64'd0 : sum - term;
		term = ((term * x2) >> 30) / 64'd72;
		sum  = sum + term;
		term = ((term * x2) >> 30) / 64'd110;
		sum  = (term > sum) ? 64'd0 : sum - term;
		term = ((term * x2) >> 30) / 64'd156;
		sum  = sum + term;
		term = ((term * x2) >> 30) / 64'd210;
		sum  = (term > sum) ? 64'd0 : sum - term;
		term = ((term * x2) >> 30) / 64'd272;
		sum  = sum + term;
		entry = (sum * 64'd32768 + (ONE_Q30 >> 1)) >> 30;
		if (entry > 64'd32768) begin
			entry = 64'd32768;
		end
		return entry[15:0];
	endfunction

endpackage

@@ rtl/wsg_sine_rom.sv @@
// Quarter-wave sine ROM with registered read port.
module wsg_sine_rom #(
	parameter int TAB_BITS = wsg_pkg::SINE_TABLE_BITS_DEF
) (
	input  logic                clk,
	input  logic                en,
	input  logic [TAB_BITS:0]   addr,
	output logic [15:0]         rd_data
);
	import wsg_pkg::*;

	localparam int DEPTH = (1 << TAB_BITS) + 1;

	logic [15:0] rom [DEPTH];
	logic [15:0] data_q;

	// constant contents, folded at elaboration
	for (genvar k = 0; k < DEPTH; k++) begin : g_rom
		assign rom[k] = sine_entry(k, TAB_BITS);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= rom[addr];
		end
	end

	assign rd_data = data_q;

endmodule

@@ rtl/waveform_sample_generator_unit.sv @@
// Direct digital synthesis sample source: top level with config registers and pipeline.
//
// Each input transaction (a tick, with its restart flag) yields exactly one
// output transaction carrying a signed 16-bit sample of the selected waveform
// (sine, cosine, triangle, square or constant) scaled by the signed amplitude
// and saturated to +/-32767. Throughput is one sample per clock while the
// output side does not stall; the result passes through three register
// stages: the phase step and registered quarter-wave ROM read
// (loaded on the accepting edge), the 16x17 amplitude multiply, and
// rounding/saturation into the output register.
// Stages advance independently, so bubbles are squeezed out when the output
// side stalls; in_ready follows out_ready combinationally through the stage
// enables. The phase accumulator is PHASE_BITS wide, cleared by reset and by
// a tick with restart set (that tick then uses phase zero), and advances by
// phase_step once per tick, wrapping. Its top 32 bits are the Q0.32 phase.
// Config registers: index 0 wave_mode (0 sine, 1 cosine, 2 triangle,
// 3 square, 4 constant, others give 0), index 1 phase_step, index 2
// amplitude. cfg_ready is always high; writes to index 3 are dropped. Write
// config only while no transaction is in flight. The sine ROM holds
// 2^SINE_TABLE_BITS+1 entries, read without interpolation.
module waveform_sample_generator_unit #(
	parameter int PHASE_BITS      = wsg_pkg::PHASE_BITS_DEF,
	parameter int SINE_TABLE_BITS = wsg_pkg::SINE_TABLE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [wsg_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [31:0]                         cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                restart,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [wsg_pkg::SAMPLE_W-1:0] sample
);
	import wsg_pkg::*;

	localparam logic [SINE_TABLE_BITS:0] TAB_FULL = (SINE_TABLE_BITS+1)'(1) << SINE_TABLE_BITS;

	// config registers
	logic [2:0]         wave_mode_q;
	logic [31:0]        phase_step_q;
	logic signed [15:0] amplitude_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_mode_q  <= '0;
			phase_step_q <= '0;
			amplitude_q  <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_WAVE_MODE:  wave_mode_q  <= cfg_data[2:0];
				REG_PHASE_STEP: phase_step_q <= cfg_data;
				REG_AMPLITUDE:  amplitude_q  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// stage enables: a stage moves when it is empty or its successor moves
	logic v_s1, v_s2, out_valid_q;
	logic en_s1, en_s2, en_s3;
	logic in_acc;

	assign en_s3    = !out_valid_q || out_ready;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;
	assign in_acc   = in_valid && in_ready;

	// phase accumulator
	logic [PHASE_BITS-1:0]  phase_q;
	logic [PHASE_BITS-1:0]  acc_cur;
	logic [PHASE_BITS+31:0] step_wide;
	logic [PHASE_BITS+31:0] p_wide;
	logic [31:0]            p;

	assign acc_cur   = restart ? '0 : phase_q;
	// align the 32-bit step and the accumulator top to Q0.32
	assign step_wide = {phase_step_q, PHASE_BITS'(0)} >> 32;
	assign p_wide    = {acc_cur, 32'b0} >> PHASE_BITS;
	assign p         = p_wide[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (in_acc) begin
			phase_q <= acc_cur + step_wide[PHASE_BITS-1:0];
		end
	end

	// sine/cosine ROM addressing
	logic [31:0]              ps;
	logic [1:0]               quad;
	logic [SINE_TABLE_BITS-1:0] idx;
	logic [SINE_TABLE_BITS:0] tab_addr;
	logic [15:0]              tab_s1;

	assign ps       = (wave_mode_q == MODE_COSINE) ? p + PH_QUARTER : p;
	assign quad     = ps[31:30];
	assign idx      = ps[29 -: SINE_TABLE_BITS];
	assign tab_addr = quad[0] ? TAB_FULL - {1'b0, idx} : {1'b0, idx};

	wsg_sine_rom #(
		.TAB_BITS (SINE_TABLE_BITS)
	) u_rom (
		.clk     (clk),
		.en      (en_s1),
		.addr    (tab_addr),
		.rd_data (tab_s1)
	);

	// non-table waveforms in Q1.15 (17-bit signed, +/-32768)
	logic [31:0]        d_mid;
	logic [31:0]        d_top;
	logic signed [16:0] u_oth;
	logic               use_tab;

	assign d_mid = p - PH_QUARTER;
	assign d_top = p - PH_THREE_QUARTER;

	always_comb begin
		u_oth   = '0;
		use_tab = 1'b0;
		case (wave_mode_q)
			MODE_SINE, MODE_COSINE: use_tab = 1'b1;
			MODE_TRIANGLE: begin
				if (p <= PH_QUARTER) begin
					u_oth = $signed(p[31:15]);
				end else if (p < PH_THREE_QUARTER) begin
					u_oth = 17'(18'sd32768 - $signed({1'b0, d_mid[31:15]}));
				end else begin
					u_oth = 17'(-18'sd32768 + $signed({1'b0, d_top[31:15]}));
				end
			end
			MODE_SQUARE:   u_oth = (p <= PH_HALF) ? 17'sd32768 : -17'sd32768;
			MODE_CONSTANT: u_oth = 17'sd32768;
			default:       u_oth = '0;   // undefined modes give silence
		endcase
	end

	// stage 1
	logic               use_tab_s1;
	logic               neg_s1;
	logic signed [16:0] u_oth_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			use_tab_s1 <= use_tab;
			neg_s1     <= quad[1];
			u_oth_s1   <= u_oth;
		end
	end

	// stage 2: amplitude multiply
	logic signed [16:0] tab_signed;
	logic signed [16:0] u_s1;
	logic signed [32:0] prod;
	logic signed [32:0] prod_s2;

	assign tab_signed = $signed({1'b0, tab_s1});
	assign u_s1       = use_tab_s1 ? (neg_s1 ? -tab_signed : tab_signed) : u_oth_s1;
	assign prod       = 33'(amplitude_q) * 33'(u_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			prod_s2 <= prod;
		end
	end

	// stage 3: round half away from zero, saturate to +/-32767
	logic [32:0]        mag;
	logic [32:0]        rnd;
	logic [14:0]        sat;
	logic signed [15:0] sample_q;

	assign mag = prod_s2[32] ? 33'(-prod_s2) : 33'(prod_s2);
	assign rnd = (mag + 33'd16384) >> 15;
	assign sat = (rnd > 33'd32767) ? 15'h7FFF : rnd[14:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en_s3) begin
			out_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			sample_q <= prod_s2[32] ? -$signed({1'b0, sat}) : $signed({1'b0, sat});
		end
	end

	assign out_valid = out_valid_q;
	assign sample    = sample_q;

endmodule
